// ===== src/qlu_pkg.sv =====
// ----------------------------------------------------------------------------
// qlu_pkg: shared definitions for the Q-table update block
// Datapath operation codes, configuration register indexes and the command
// and status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package qlu_pkg;

    localparam int OP_W = 4;

    localparam logic [OP_W-1:0] OP_NONE       = 4'd0;
    localparam logic [OP_W-1:0] OP_CLEAR      = 4'd1;
    localparam logic [OP_W-1:0] OP_MOD        = 4'd2;
    localparam logic [OP_W-1:0] OP_SCAN_START = 4'd3;
    localparam logic [OP_W-1:0] OP_SCAN       = 4'd4;
    localparam logic [OP_W-1:0] OP_GMUL       = 4'd5;
    localparam logic [OP_W-1:0] OP_TARGET     = 4'd6;
    localparam logic [OP_W-1:0] OP_MMUL       = 4'd7;
    localparam logic [OP_W-1:0] OP_WRITE      = 4'd8;
    localparam logic [OP_W-1:0] OP_EMUL       = 4'd9;
    localparam logic [OP_W-1:0] OP_EFLOOR     = 4'd10;
    localparam logic [OP_W-1:0] OP_OUT        = 4'd11;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REWARD_VALUE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_FACTOR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPLORE_FLOOR = 3'd4;

    localparam int CFG_DATA_W = 24;

    typedef struct packed {
        logic            accept;
        logic [OP_W-1:0] op;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic mod_last;
        logic scan_last;
        logic prev_valid;
        logic explore;
        logic out_free;
    } t_sts;

endpackage

// ===== src/qlu_ctrl.sv =====
// ----------------------------------------------------------------------------
// qlu_ctrl: sequencing controller
// Steps the datapath through table clearing, hash reduction, row scans, the
// value update, the epsilon decay, the action decision and the result hand-off.
// ----------------------------------------------------------------------------
module qlu_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_last_word,
    input  qlu_pkg::t_sts     i_sts,
    output logic              o_in_stall,
    output qlu_pkg::t_cmd     o_cmd
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_MOD   = 4'd2;
    localparam logic [3:0] S_SC1S  = 4'd3;
    localparam logic [3:0] S_SC1   = 4'd4;
    localparam logic [3:0] S_GMUL  = 4'd5;
    localparam logic [3:0] S_TGT   = 4'd6;
    localparam logic [3:0] S_MMUL  = 4'd7;
    localparam logic [3:0] S_WR    = 4'd8;
    localparam logic [3:0] S_EMUL  = 4'd9;
    localparam logic [3:0] S_EFL   = 4'd10;
    localparam logic [3:0] S_DEC   = 4'd11;
    localparam logic [3:0] S_SC2S  = 4'd12;
    localparam logic [3:0] S_SC2   = 4'd13;
    localparam logic [3:0] S_FIN   = 4'd14;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state      = r_state;
        o_cmd.accept = 1'b0;
        o_cmd.op     = qlu_pkg::OP_NONE;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.op = qlu_pkg::OP_CLEAR;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_last_word) begin
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.op = qlu_pkg::OP_MOD;
                if (i_sts.mod_last) begin
                    n_state = i_sts.prev_valid ? S_SC1S : S_DEC;
                end
            end
            S_SC1S: begin
                o_cmd.op = qlu_pkg::OP_SCAN_START;
                n_state  = S_SC1;
            end
            S_SC1: begin
                o_cmd.op = qlu_pkg::OP_SCAN;
                if (i_sts.scan_last) begin
                    n_state = S_GMUL;
                end
            end
            S_GMUL: begin
                o_cmd.op = qlu_pkg::OP_GMUL;
                n_state  = S_TGT;
            end
            S_TGT: begin
                o_cmd.op = qlu_pkg::OP_TARGET;
                n_state  = S_MMUL;
            end
            S_MMUL: begin
                o_cmd.op = qlu_pkg::OP_MMUL;
                n_state  = S_WR;
            end
            S_WR: begin
                o_cmd.op = qlu_pkg::OP_WRITE;
                n_state  = S_EMUL;
            end
            S_EMUL: begin
                o_cmd.op = qlu_pkg::OP_EMUL;
                n_state  = S_EFL;
            end
            S_EFL: begin
                o_cmd.op = qlu_pkg::OP_EFLOOR;
                n_state  = S_DEC;
            end
            S_DEC: begin
                n_state = i_sts.explore ? S_FIN : S_SC2S;
            end
            S_SC2S: begin
                o_cmd.op = qlu_pkg::OP_SCAN_START;
                n_state  = S_SC2;
            end
            S_SC2: begin
                o_cmd.op = qlu_pkg::OP_SCAN;
                if (i_sts.scan_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.op = qlu_pkg::OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/qlu_dpath.sv =====
// ----------------------------------------------------------------------------
// qlu_dpath: datapath of the Q-table update block
// Holds the value table, the hash and remainder unit, the row scan, the
// fixed-point update arithmetic, epsilon, configuration and the result register.
// ----------------------------------------------------------------------------
module qlu_dpath #(
    parameter int TABLE_ENTRIES = 8192,
    parameter int ACTION_COUNT  = 12,
    parameter int Q_WIDTH       = 24
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  qlu_pkg::t_cmd                        i_cmd,
    output qlu_pkg::t_sts                        o_sts,
    input  logic                                 i_cfg_we,
    input  logic [qlu_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [qlu_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic [31:0]                          i_word_value,
    input  logic                                 i_last_word,
    input  logic [15:0]                          i_explore_draw,
    input  logic [3:0]                           i_explore_pick,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [3:0]                           o_chosen_action,
    output logic                                 o_explored
);

    localparam int IW    = $clog2(TABLE_ENTRIES);
    localparam int TOTAL = TABLE_ENTRIES * ACTION_COUNT;
    localparam int AWD   = $clog2(TOTAL);
    localparam int PW    = Q_WIDTH + 20;
    localparam int SH    = $clog2(TABLE_ENTRIES + 1) - 1;

    // The quotient estimate from this reciprocal is exact or one too small.
    localparam logic [32:0] MRECIP = 33'((64'd1 << (32 + SH)) / 64'(TABLE_ENTRIES));

    localparam logic signed [PW-1:0] QMAX =
        {{(PW - Q_WIDTH + 1){1'b0}}, {(Q_WIDTH - 1){1'b1}}};
    localparam logic signed [PW-1:0] QMIN = ~QMAX;

    function automatic logic signed [Q_WIDTH-1:0] sat_q(input logic signed [PW-1:0] v);
        logic signed [Q_WIDTH-1:0] res;
        if (v > QMAX) begin
            res = QMAX[Q_WIDTH-1:0];
        end else if (v < QMIN) begin
            res = QMIN[Q_WIDTH-1:0];
        end else begin
            res = v[Q_WIDTH-1:0];
        end
        return res;
    endfunction

    function automatic logic signed [PW-1:0] rnd16(input logic signed [PW-1:0] x);
        logic signed [PW-1:0] t;
        t = x + PW'(32768);
        return t >>> 16;
    endfunction

    // Configuration
    logic [15:0]        r_alpha;
    logic [15:0]        r_gamma;
    logic signed [23:0] r_reward;
    logic [15:0]        r_decay;
    logic [16:0]        r_floor;

    // Control state
    logic [31:0]        r_hash;
    logic [16:0]        r_eps;
    logic               r_prev_valid;
    logic [IW-1:0]      r_prev_idx;
    logic [3:0]         r_prev_act;
    logic [AWD-1:0]     r_clr_addr;
    logic [4:0]         r_mod_cnt;
    logic               r_ov;
    logic               r_rd_scan;

    // Payload
    logic [31:0]               r_src;
    logic [31:0]               r_mq;
    logic [17:0]               r_rem;
    logic [IW-1:0]             r_cur;
    logic [15:0]               r_draw;
    logic [3:0]                r_pick;
    logic [4:0]                r_sa;
    logic [3:0]                r_rd_tag;
    logic signed [Q_WIDTH-1:0] r_rd;
    logic signed [Q_WIDTH-1:0] r_best;
    logic [3:0]                r_best_a;
    logic signed [Q_WIDTH-1:0] r_old;
    logic signed [Q_WIDTH-1:0] r_target;
    logic signed [PW-1:0]      r_p;
    logic signed [PW-1:0]      r_p2;
    logic [32:0]               r_pe;
    logic [3:0]                r_act;
    logic                      r_expl;

    logic [Q_WIDTH-1:0]        r_mem [TOTAL];

    logic [31:0]               w_hash_next;
    logic [64:0]               w_mprod;
    logic [31:0]               w_mq;
    logic [47:0]               w_qn;
    logic [17:0]               w_rem;
    logic [IW-1:0]             w_rem_next;
    logic [AWD-1:0]            w_row;
    logic [AWD-1:0]            w_slot;
    logic [AWD-1:0]            w_raddr;
    logic [AWD-1:0]            w_waddr;
    logic [Q_WIDTH-1:0]        w_wdata;
    logic                      w_we;
    logic signed [Q_WIDTH-1:0] w_rew;
    logic signed [Q_WIDTH-1:0] w_tgt;
    logic signed [Q_WIDTH-1:0] w_new;
    logic [16:0]               w_one_minus;
    logic [33:0]               w_e_sum;
    logic [16:0]               w_e;
    logic                      w_explore;
    logic [4:0]                w_pick_mod;
    logic                      w_out_free;

    assign w_hash_next = (r_hash << 5) - r_hash + i_word_value;
    assign w_mprod     = 65'(r_src) * 65'(MRECIP);
    assign w_mq        = 32'(w_mprod >> (32 + SH));
    assign w_qn        = 48'(r_mq) * 48'(TABLE_ENTRIES);
    assign w_rem       = 18'(r_src - w_qn[31:0]);
    assign w_rem_next  = (r_rem >= 18'(TABLE_ENTRIES))
                       ? IW'(r_rem - 18'(TABLE_ENTRIES))
                       : IW'(r_rem);

    assign w_row  = AWD'(r_cur) * AWD'(ACTION_COUNT);
    assign w_slot = AWD'(r_prev_idx) * AWD'(ACTION_COUNT) + AWD'(r_prev_act);

    assign w_rew       = sat_q(PW'(r_reward));
    assign w_tgt       = sat_q(PW'(w_rew) + rnd16(r_p));
    assign w_new       = sat_q(rnd16(r_p + r_p2));
    assign w_one_minus = 17'h10000 - {1'b0, r_alpha};
    assign w_e_sum     = {1'b0, r_pe} + 34'd32768;
    assign w_e         = w_e_sum[32:16];
    assign w_explore   = (r_eps > r_floor) && ({1'b0, r_draw} < r_eps);
    assign w_out_free  = !r_ov || !i_out_stall;

    always_comb begin
        w_pick_mod = {1'b0, r_pick};
        for (int k = 0; k < 8; k++) begin
            if (w_pick_mod >= 5'(ACTION_COUNT)) begin
                w_pick_mod = w_pick_mod - 5'(ACTION_COUNT);
            end
        end
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_clr_addr;
        w_wdata = '0;
        w_raddr = w_row + AWD'(r_sa[3:0]);
        unique case (i_cmd.op)
            qlu_pkg::OP_CLEAR: begin
                w_we = 1'b1;
            end
            qlu_pkg::OP_WRITE: begin
                w_we    = 1'b1;
                w_waddr = w_slot;
                w_wdata = w_new;
            end
            qlu_pkg::OP_SCAN_START: begin
                w_raddr = w_row;
            end
            qlu_pkg::OP_GMUL: begin
                w_raddr = w_slot;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_last_word) begin
            r_src  <= w_hash_next;
            r_cur  <= '0;
            r_draw <= i_explore_draw;
            r_pick <= i_explore_pick;
        end
        unique case (i_cmd.op)
            qlu_pkg::OP_MOD: begin
                if (r_mod_cnt == 5'd0) begin
                    r_mq <= w_mq;
                end else if (r_mod_cnt == 5'd1) begin
                    r_rem <= w_rem;
                end else begin
                    r_cur <= w_rem_next;
                end
            end
            qlu_pkg::OP_SCAN_START: begin
                r_sa     <= 5'd1;
                r_rd_tag <= 4'd0;
            end
            qlu_pkg::OP_SCAN: begin
                r_sa     <= r_sa + 5'd1;
                r_rd_tag <= r_sa[3:0];
                if (r_rd_scan) begin
                    if (r_rd_tag == 4'd0 || r_rd > r_best) begin
                        r_best   <= r_rd;
                        r_best_a <= r_rd_tag;
                    end
                end
            end
            qlu_pkg::OP_GMUL: begin
                r_p <= $signed({1'b0, r_gamma}) * r_best;
            end
            qlu_pkg::OP_TARGET: begin
                r_target <= w_tgt;
                r_old    <= r_rd;
            end
            qlu_pkg::OP_MMUL: begin
                r_p  <= $signed({1'b0, w_one_minus}) * r_old;
                r_p2 <= $signed({1'b0, r_alpha}) * r_target;
            end
            qlu_pkg::OP_EMUL: begin
                r_pe <= r_eps * r_decay;
            end
            qlu_pkg::OP_OUT: begin
                r_act  <= w_explore ? w_pick_mod[3:0] : r_best_a;
                r_expl <= w_explore;
            end
            default: begin
                r_sa <= r_sa;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha      <= 16'd6554;
            r_gamma      <= 16'd62259;
            r_reward     <= 24'sd6554;
            r_decay      <= 16'd65208;
            r_floor      <= 17'd655;
            r_hash       <= '0;
            r_eps        <= 17'h10000;
            r_prev_valid <= 1'b0;
            r_prev_idx   <= '0;
            r_prev_act   <= '0;
            r_clr_addr   <= '0;
            r_mod_cnt    <= '0;
            r_ov         <= 1'b0;
            r_rd_scan    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    qlu_pkg::CFG_LEARN_RATE:    r_alpha  <= i_cfg_data[15:0];
                    qlu_pkg::CFG_DISCOUNT:      r_gamma  <= i_cfg_data[15:0];
                    qlu_pkg::CFG_REWARD_VALUE:  r_reward <= i_cfg_data;
                    qlu_pkg::CFG_DECAY_FACTOR:  r_decay  <= i_cfg_data[15:0];
                    qlu_pkg::CFG_EXPLORE_FLOOR: r_floor  <= i_cfg_data[16:0];
                    default: begin
                        r_floor <= r_floor;
                    end
                endcase
            end
            if (i_cmd.accept) begin
                r_hash <= i_last_word ? 32'd0 : w_hash_next;
                if (i_last_word) begin
                    r_mod_cnt <= '0;
                end
            end
            unique case (i_cmd.op)
                qlu_pkg::OP_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AWD'(1);
                end
                qlu_pkg::OP_MOD: begin
                    r_mod_cnt <= r_mod_cnt + 5'd1;
                end
                qlu_pkg::OP_SCAN_START: begin
                    r_rd_scan <= 1'b1;
                end
                qlu_pkg::OP_SCAN: begin
                    r_rd_scan <= (r_sa < 5'(ACTION_COUNT));
                end
                qlu_pkg::OP_EFLOOR: begin
                    r_eps <= (w_e < r_floor) ? r_floor : w_e;
                end
                qlu_pkg::OP_OUT: begin
                    r_prev_valid <= 1'b1;
                    r_prev_idx   <= r_cur;
                    r_prev_act   <= w_explore ? w_pick_mod[3:0] : r_best_a;
                end
                default: begin
                    r_rd_scan <= r_rd_scan;
                end
            endcase
            if (i_cmd.op == qlu_pkg::OP_OUT) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_sts.clr_last   = (r_clr_addr == AWD'(TOTAL - 1));
    assign o_sts.mod_last   = (r_mod_cnt == 5'd2);
    assign o_sts.scan_last  = r_rd_scan && (r_rd_tag == 4'(ACTION_COUNT - 1));
    assign o_sts.prev_valid = r_prev_valid;
    assign o_sts.explore    = w_explore;
    assign o_sts.out_free   = w_out_free;

    assign o_out_valid     = r_ov;
    assign o_chosen_action = r_act;
    assign o_explored      = r_expl;

endmodule

// ===== src/q_learning_table_update_top.sv =====
// The block folds state words into a hash and, on each final word, picks an
// action; when a previous step exists, it first updates the value of the
// previous state and action and decays epsilon. A final word is reduced to a
// table index by a reciprocal multiplication and one correcting subtraction;
// then, only when a previous step exists, the entry row is scanned through
// the table's single read port once before the update, and the update and
// decay follow. The action is then decided, and a second scan of the row
// follows when the action is not explored. The result is loaded into the
// output register once it is free. After reset the table is cleared one entry
// per cycle before the first transaction is taken; configuration writes are
// accepted throughout.
// ----------------------------------------------------------------------------
// q_learning_table_update_top: tabular Q-learning with epsilon-greedy choice
// Top level joining the sequencing controller and the datapath.
// ----------------------------------------------------------------------------
module q_learning_table_update_top #(
    parameter int TABLE_ENTRIES = 8192,
    parameter int ACTION_COUNT  = 12,
    parameter int Q_WIDTH       = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [qlu_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [qlu_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [31:0]                     i_word_value,
    input  logic                            i_last_word,
    input  logic [15:0]                     i_explore_draw,
    input  logic [3:0]                      i_explore_pick,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [3:0]                      o_chosen_action,
    output logic                            o_explored
);

    qlu_pkg::t_cmd w_cmd;
    qlu_pkg::t_sts w_sts;

    qlu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_word (i_last_word),
        .i_sts       (w_sts),
        .o_in_stall  (o_in_stall),
        .o_cmd       (w_cmd)
    );

    qlu_dpath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .ACTION_COUNT  (ACTION_COUNT),
        .Q_WIDTH       (Q_WIDTH)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_word_value    (i_word_value),
        .i_last_word     (i_last_word),
        .i_explore_draw  (i_explore_draw),
        .i_explore_pick  (i_explore_pick),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_chosen_action (o_chosen_action),
        .o_explored      (o_explored)
    );

`ifndef SYNTHESIS
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == qlu_pkg::OP_OUT) |=> o_out_valid)
        else $error("result register not loaded");

    a_out_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.op == qlu_pkg::OP_OUT))
        else $error("result appeared without a load");

    a_upd_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == qlu_pkg::OP_WRITE) |-> w_sts.prev_valid)
        else $error("update without a previous step");

    a_act_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({1'b0, o_chosen_action} < 5'(ACTION_COUNT)))
        else $error("chosen action out of range");
`endif

endmodule
